/* rtl/mpep_pkg.sv */
// ----------------------------------------------------------------------------
// mpep_pkg - shared types and constants of the MRP PDU event parser
// Parse phases, result word layout, protocol constants and small helpers.
// ----------------------------------------------------------------------------
package mpep_pkg;

	typedef enum logic [3:0] {
		PH_DST     = 4'd0,
		PH_SRC     = 4'd1,
		PH_ETYPE   = 4'd2,
		PH_TCI     = 4'd3,
		PH_VERSION = 4'd4,
		PH_ATYPE   = 4'd5,
		PH_ALEN    = 4'd6,
		PH_LLEN    = 4'd7,
		PH_VHDR    = 4'd8,
		PH_FIRST   = 4'd9,
		PH_THREE   = 4'd10,
		PH_FOUR    = 4'd11,
		PH_PAD     = 4'd12,
		PH_TAIL    = 4'd13,
		PH_OTHER   = 4'd14,
		PH_ERROR   = 4'd15
	} phase_t;

	localparam logic [2:0] KIND_FIRST  = 3'd0;
	localparam logic [2:0] KIND_THREE  = 3'd1;
	localparam logic [2:0] KIND_FOUR   = 3'd2;
	localparam logic [2:0] KIND_LEAVE  = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MALFORM = 2'd1;
	localparam logic [1:0] ST_NOT_MRP = 2'd2;

	localparam logic [15:0] ETYPE_MSRP = 16'h22EA;
	localparam logic [15:0] ETYPE_MVRP = 16'h88F5;
	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_QINQ = 16'h88A8;

	localparam logic [7:0] ATYPE_LISTENER = 8'd3;
	localparam logic [2:0] LEAVE_ALL_EVT  = 3'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic        is_msrp;
		logic [7:0]  attr_type;
		logic [8:0]  message_index;
		logic [9:0]  vector_index;
		logic [11:0] value_index;
		logic [7:0]  value;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]        n;
		result_t [3:0]     res;
	} batch_t;

	// Required attribute length of the MSRP attribute types one to four
	function automatic logic [6:0] msrp_len(input logic [7:0] t);
		logic [6:0] l;
		case (t)
			8'd1: l = 7'd25;
			8'd2: l = 7'd34;
			8'd3: l = 7'd8;
			8'd4: l = 7'd4;
			default: l = 7'd0;
		endcase
		return l;
	endfunction

	// Exact divide by six for 8-bit values by reciprocal multiply
	function automatic logic [7:0] div6(input logic [7:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'd171;
		return 8'(p >> 10);
	endfunction

	function automatic result_t mk_res(input logic [2:0] kind, input logic msrp,
			input logic [7:0] at, input logic [8:0] mi, input logic [9:0] vi,
			input logic [11:0] xi, input logic [7:0] val);
		result_t r;
		r.kind           = kind;
		r.is_msrp        = msrp;
		r.attr_type      = at;
		r.message_index  = mi;
		r.vector_index   = vi;
		r.value_index    = xi;
		r.value          = val;
		r.status         = ST_OK;
		r.last           = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/mpep_in_if.sv */
// ----------------------------------------------------------------------------
// mpep_in_if - frame byte channel
// Valid/ready channel carrying one frame byte and the count of bytes after it.
// ----------------------------------------------------------------------------
interface mpep_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [10:0] bytes_after;

	modport source(output valid, output data_byte, output bytes_after, input ready);
	modport sink(input valid, input data_byte, input bytes_after, output ready);
endinterface

/* rtl/mpep_out_if.sv */
// ----------------------------------------------------------------------------
// mpep_out_if - result channel
// Valid/ready channel carrying one parsed event or frame status word.
// ----------------------------------------------------------------------------
interface mpep_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic        is_msrp;
	logic [7:0]  attr_type;
	logic [8:0]  message_index;
	logic [9:0]  vector_index;
	logic [11:0] value_index;
	logic [7:0]  value;
	logic [1:0]  status;
	logic        last;

	modport source(output valid, output kind, output is_msrp, output attr_type,
		output message_index, output vector_index, output value_index,
		output value, output status, output last, input ready);
	modport sink(input valid, input kind, input is_msrp, input attr_type,
		input message_index, input vector_index, input value_index,
		input value, input status, input last, output ready);
endinterface

/* rtl/mrp_pdu_event_parser_top.sv */
// ----------------------------------------------------------------------------
// mrp_pdu_event_parser_top - MVRP/MSRP PDU event parser
// Parses Ethernet frames byte by byte and emits MRP events and frame status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one frame byte per word with the count of bytes that follow;
//   a count of zero marks the last byte of the frame.
//   out_ch carries leave-all markers, first-value bytes, three- and
//   four-packed events in stream order, and one status word per frame.
//   Each byte is parsed in the cycle it is taken; its words (zero to four)
//   sit in a small buffer and leave through the output register one per
//   cycle while out_ch is ready, each word going from the buffer to the output register.
//   A byte is taken once the buffer holds at most one word that is moving
//   out, so a byte can be taken while the last word of the one before moves out.
//   When out_ch stalls the buffer fills and in_ch.ready drops; nothing is lost.
//   Reset clears the parse state to the start of a frame and empties the
//   output; no clearing pass is needed.
//   On a malformed frame the status word says so; discard that frame's words.
// ----------------------------------------------------------------------------
module mrp_pdu_event_parser_top #(
	parameter int MAX_FRAME_BYTES   = 2048,
	parameter int MAX_VECTOR_VALUES = 4096,
	parameter int MAX_MESSAGES      = 256,
	parameter int MAX_ATTR_LEN      = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	mpep_in_if.sink    in_ch,
	mpep_out_if.source out_ch
);
	import mpep_pkg::*;

	batch_t batch;
	logic   can_take;
	logic   take;

	assign in_ch.ready = can_take;
	assign take        = in_ch.valid && can_take;

	mpep_parser #(
		.MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
		.MAX_VECTOR_VALUES(MAX_VECTOR_VALUES),
		.MAX_MESSAGES     (MAX_MESSAGES),
		.MAX_ATTR_LEN     (MAX_ATTR_LEN)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (in_ch.data_byte),
		.bytes_after(in_ch.bytes_after),
		.batch      (batch)
	);

	mpep_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.batch   (batch),
		.can_take(can_take),
		.out_ch  (out_ch)
	);

`ifndef ASSERT_OFF
	// A status word always closes the words of its byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_STATUS |-> out_ch.last)
		else $error("status word without last");

	// Only status words carry a status code
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind != KIND_STATUS |-> out_ch.status == ST_OK)
		else $error("status code on an event word");

	// A batch never exceeds four words
	a_batch_size: assert property (@(posedge clk) disable iff (!arst_n)
		batch.n <= 3'd4)
		else $error("batch larger than four words");
`endif

endmodule

/* rtl/mpep_parser.sv */
// ----------------------------------------------------------------------------
// mpep_parser - frame and MRP PDU parse state
// Holds the parse registers and turns one frame byte into up to four results.
// ----------------------------------------------------------------------------
module mpep_parser #(
	parameter int MAX_FRAME_BYTES   = 2048,
	parameter int MAX_VECTOR_VALUES = 4096,
	parameter int MAX_MESSAGES      = 256,
	parameter int MAX_ATTR_LEN      = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic [10:0]         bytes_after,
	output mpep_pkg::batch_t    batch
);
	import mpep_pkg::*;

	localparam int PW = $clog2(MAX_FRAME_BYTES);
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_FRAME_BYTES - 1);

	typedef struct packed {
		logic       fail;
		logic [8:0] msg;
		logic       pad;
	} em_t;

	phase_t      phase_q, n_phase;
	logic [PW-1:0] pos_q, n_pos;
	logic [6:0]  fcnt_q, n_fcnt;
	logic [15:0] fshift_q, n_fshift;
	logic        msrp_q, n_msrp;
	logic [7:0]  atype_q, n_atype;
	logic [6:0]  alen_q, n_alen;
	logic [10:0] lend_q, n_lend;
	logic [12:0] nval_q, n_nval;
	logic [11:0] evcnt_q, n_evcnt;
	logic [8:0]  msg_q, n_msg;
	logic [9:0]  vcnt_q, n_vcnt;
	logic [7:0]  ver_q, n_ver;
	logic        err_q, n_err;

	result_t [3:0] res;
	logic [2:0]  cnt;
	logic        run_tail, want_three, want_four, want_vdone;
	logic [15:0] hdr;
	logic [2:0]  k;
	logic [7:0]  q6, q36, mid, lo;
	logic [1:0]  st;
	em_t         em;

	// Close a message: list end check and runaway message count
	function automatic em_t end_msg(input logic msrp, input logic [11:0] rem,
			input logic [10:0] lend, input logic [8:0] msg);
		em_t e;
		logic [9:0] m;
		m      = {1'b0, msg} + 10'd1;
		e.msg  = m[8:0];
		e.fail = (msrp && (rem < {1'b0, lend})) || (32'(m) > MAX_MESSAGES);
		e.pad  = msrp && (rem > {1'b0, lend});
		return e;
	endfunction

	// Split the byte for three-packed events
	always_comb begin
		q6  = div6(data_byte);
		q36 = div6(q6);
		mid = q6 - 8'(q36 * 8'd6);
		lo  = data_byte - 8'(q6 * 8'd6);
	end

	// Next state and results for one byte
	always_comb begin
		n_phase = phase_q; n_pos = pos_q; n_fcnt = fcnt_q; n_fshift = fshift_q;
		n_msrp = msrp_q; n_atype = atype_q; n_alen = alen_q; n_lend = lend_q;
		n_nval = nval_q; n_evcnt = evcnt_q; n_msg = msg_q; n_vcnt = vcnt_q;
		n_ver = ver_q; n_err = err_q;
		res = '0; cnt = 3'd0;
		run_tail = 1'b0; want_three = 1'b0; want_four = 1'b0; want_vdone = 1'b0;
		hdr = {fshift_q[7:0], data_byte};
		k = 3'd0; st = ST_OK;
		em = end_msg(msrp_q, {1'b0, bytes_after} + 12'd1, lend_q, msg_q);

		if (pos_q >= POS_LAST && bytes_after != 11'd0) begin
			n_err = 1'b1; n_phase = PH_ERROR;
		end else begin
			case (phase_q)
				PH_DST, PH_SRC: begin
					n_fcnt = fcnt_q + 7'd1;
					if (n_fcnt >= 7'd6) begin
						n_fcnt = '0; n_fshift = '0;
						n_phase = (phase_q == PH_DST) ? PH_SRC : PH_ETYPE;
					end
				end
				PH_ETYPE: begin
					n_fshift = {fshift_q[7:0], data_byte};
					n_fcnt = fcnt_q + 7'd1;
					if (n_fcnt >= 7'd2) begin
						n_fcnt = '0;
						if (n_fshift == ETYPE_VLAN || n_fshift == ETYPE_QINQ) begin
							n_phase = PH_TCI;
						end else if (n_fshift == ETYPE_MSRP || n_fshift == ETYPE_MVRP) begin
							n_msrp = (n_fshift == ETYPE_MSRP);
							n_phase = PH_VERSION;
						end else begin
							n_phase = PH_OTHER;
						end
					end
				end
				PH_TCI: begin
					n_fcnt = fcnt_q + 7'd1;
					if (n_fcnt >= 7'd2) begin
						n_fcnt = '0; n_fshift = '0; n_phase = PH_ETYPE;
					end
				end
				PH_VERSION: begin
					n_ver = data_byte; n_msg = '0; n_phase = PH_ATYPE;
				end
				PH_ATYPE, PH_PAD: run_tail = 1'b1;
				PH_ALEN: begin
					if (data_byte == 8'd0 || 32'(data_byte) > MAX_ATTR_LEN ||
						(!msrp_q && (atype_q != 8'd1 || data_byte != 8'd2)) ||
						(msrp_q && atype_q >= 8'd1 && atype_q <= 8'd4 &&
						 data_byte != {1'b0, msrp_len(atype_q)})) begin
						n_err = 1'b1; n_phase = PH_ERROR;
					end else begin
						n_alen = data_byte[6:0]; n_vcnt = '0; n_fcnt = '0; n_fshift = '0;
						n_phase = msrp_q ? PH_LLEN : PH_VHDR;
					end
				end
				PH_LLEN: begin
					n_fshift = {fshift_q[7:0], data_byte};
					n_fcnt = fcnt_q + 7'd1;
					if (n_fcnt >= 7'd2) begin
						if (n_fshift > {5'd0, bytes_after}) begin
							n_err = 1'b1; n_phase = PH_ERROR;
						end else begin
							n_lend = bytes_after - n_fshift[10:0];
							n_fcnt = '0; n_phase = PH_VHDR;
						end
					end
				end
				PH_VHDR: begin
					if (fcnt_q == 7'd0) begin
						if (bytes_after == 11'd0 ||
							(msrp_q && ({1'b0, bytes_after} + 12'd1) <= {1'b0, lend_q})) begin
							n_msg = em.msg;
							if (em.fail) begin
								n_err = 1'b1; n_phase = PH_ERROR;
							end else begin
								n_phase = em.pad ? PH_PAD : PH_ATYPE;
								run_tail = 1'b1;
							end
						end else begin
							n_fshift = {8'd0, data_byte}; n_fcnt = 7'd1;
						end
					end else begin
						n_fcnt = '0;
						if (hdr == 16'd0) begin
							em = end_msg(msrp_q, {1'b0, bytes_after}, lend_q, msg_q);
							n_msg = em.msg;
							if (em.fail) begin
								n_err = 1'b1; n_phase = PH_ERROR;
							end else begin
								n_phase = em.pad ? PH_PAD : PH_ATYPE;
							end
						end else if (32'(hdr[12:0]) > MAX_VECTOR_VALUES) begin
							n_err = 1'b1; n_phase = PH_ERROR;
						end else begin
							n_nval = hdr[12:0];
							if (hdr[15:13] == LEAVE_ALL_EVT) begin
								res[cnt[1:0]] = mk_res(KIND_LEAVE, msrp_q, atype_q, msg_q,
									vcnt_q, 12'd0, 8'd0);
								cnt = cnt + 3'd1;
							end
							n_phase = PH_FIRST;
						end
					end
				end
				PH_FIRST: begin
					res[cnt[1:0]] = mk_res(KIND_FIRST, msrp_q, atype_q, msg_q, vcnt_q,
						{5'd0, fcnt_q}, data_byte);
					cnt = cnt + 3'd1;
					n_fcnt = fcnt_q + 7'd1;
					if (n_fcnt >= alen_q) begin
						n_fcnt = '0; want_three = 1'b1;
					end
				end
				PH_THREE: begin
					k = (fshift_q >= 16'd3) ? 3'd3 : fshift_q[2:0];
					for (int j = 0; j < 3; j++) begin
						if (3'(j) < k) begin
							res[2'(j)] = mk_res(KIND_THREE, msrp_q, atype_q, msg_q, vcnt_q,
								evcnt_q + 12'(j), (j == 0) ? q36 : (j == 1) ? mid : lo);
						end
					end
					cnt = k;
					n_evcnt = evcnt_q + 12'(k);
					n_fshift = fshift_q - 16'(k);
					if (n_fshift == 16'd0) want_four = 1'b1;
				end
				PH_FOUR: begin
					k = (fshift_q >= 16'd4) ? 3'd4 : fshift_q[2:0];
					for (int j = 0; j < 4; j++) begin
						if (3'(j) < k) begin
							res[2'(j)] = mk_res(KIND_FOUR, msrp_q, atype_q, msg_q, vcnt_q,
								evcnt_q + 12'(j), {6'd0, data_byte[7 - 2*j -: 2]});
						end
					end
					cnt = k;
					n_evcnt = evcnt_q + 12'(k);
					n_fshift = fshift_q - 16'(k);
					if (n_fshift == 16'd0) want_vdone = 1'b1;
				end
				default: ;
			endcase
		end

		// Follow-on work within the same byte: message start or list padding
		if (run_tail) begin
			case (n_phase)
				PH_ATYPE: begin
					if (bytes_after == 11'd0 || data_byte == 8'd0) begin
						n_phase = PH_TAIL;
					end else begin
						n_atype = data_byte; n_phase = PH_ALEN;
					end
				end
				PH_PAD: if (bytes_after <= lend_q) n_phase = PH_ATYPE;
				default: ;
			endcase
		end

		// Enter the packed event sections or close the vector
		if (want_three) begin
			n_evcnt = '0; n_fshift = {3'd0, nval_q};
			if (nval_q == 13'd0) want_four = 1'b1;
			else n_phase = PH_THREE;
		end
		if (want_four) begin
			if (msrp_q && atype_q == ATYPE_LISTENER && nval_q != 13'd0) begin
				n_evcnt = '0; n_fshift = {3'd0, nval_q}; n_phase = PH_FOUR;
			end else begin
				want_vdone = 1'b1;
			end
		end
		if (want_vdone) begin
			n_vcnt = vcnt_q + 10'd1; n_fcnt = '0; n_phase = PH_VHDR;
		end

		if (pos_q < POS_LAST) n_pos = pos_q + PW'(1);

		// Close the frame with a status word
		if (bytes_after == 11'd0) begin
			if (!n_err) begin
				case (n_phase)
					PH_ATYPE, PH_TAIL, PH_OTHER, PH_PAD: ;
					PH_VHDR: begin
						em = end_msg(n_msrp, 12'd0, n_lend, n_msg);
						if (n_fcnt != 7'd0 || em.fail) n_err = 1'b1;
					end
					default: n_err = 1'b1;
				endcase
			end
			if (cnt >= 3'd4) begin
				n_err = 1'b1; cnt = 3'd0;
			end
			st = n_err ? ST_MALFORM : (n_phase == PH_OTHER) ? ST_NOT_MRP : ST_OK;
			res[cnt[1:0]] = mk_res(KIND_STATUS, n_msrp, 8'd0, 9'd0, 10'd0, 12'd0, n_ver);
			res[cnt[1:0]].status = st;
			cnt = cnt + 3'd1;
			n_phase = PH_DST; n_pos = '0; n_fcnt = '0; n_fshift = '0; n_msrp = 1'b0;
			n_atype = '0; n_alen = '0; n_lend = '0; n_nval = '0; n_evcnt = '0;
			n_msg = '0; n_vcnt = '0; n_ver = '0; n_err = 1'b0;
		end

		// Mark the last word of this byte
		if (cnt != 3'd0) res[2'(cnt - 3'd1)].last = 1'b1;

		batch.n   = cnt;
		batch.res = res;
	end

	// Advance the parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DST; pos_q <= '0; fcnt_q <= '0; fshift_q <= '0;
			msrp_q <= 1'b0; atype_q <= '0; alen_q <= '0; lend_q <= '0;
			nval_q <= '0; evcnt_q <= '0; msg_q <= '0; vcnt_q <= '0;
			ver_q <= '0; err_q <= 1'b0;
		end else if (take) begin
			phase_q <= n_phase; pos_q <= n_pos; fcnt_q <= n_fcnt; fshift_q <= n_fshift;
			msrp_q <= n_msrp; atype_q <= n_atype; alen_q <= n_alen; lend_q <= n_lend;
			nval_q <= n_nval; evcnt_q <= n_evcnt; msg_q <= n_msg; vcnt_q <= n_vcnt;
			ver_q <= n_ver; err_q <= n_err;
		end
	end

endmodule

/* rtl/mpep_emit.sv */
// ----------------------------------------------------------------------------
// mpep_emit - result buffer and output register
// Holds the words of one byte and hands them out one per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module mpep_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  mpep_pkg::batch_t batch,
	output logic             can_take,
	mpep_out_if.source       out_ch
);
	import mpep_pkg::*;

	result_t [3:0] res_q;
	logic [2:0]    rem_q;
	logic [1:0]    idx_q;
	logic          ovalid_q;
	result_t       odata_q;
	logic          load;
	logic          take;

	// Move a word to the output register when it is free or drained
	assign load     = (rem_q != 3'd0) && (!ovalid_q || out_ch.ready);
	assign can_take = (rem_q == 3'd0) || (rem_q == 3'd1 && load);
	assign take     = in_valid && can_take;

	// Hold the batch and count down the words left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			rem_q <= batch.n;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= batch.res;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) odata_q <= res_q[idx_q];
	end

	assign out_ch.valid          = ovalid_q;
	assign out_ch.kind           = odata_q.kind;
	assign out_ch.is_msrp        = odata_q.is_msrp;
	assign out_ch.attr_type      = odata_q.attr_type;
	assign out_ch.message_index  = odata_q.message_index;
	assign out_ch.vector_index   = odata_q.vector_index;
	assign out_ch.value_index    = odata_q.value_index;
	assign out_ch.value          = odata_q.value;
	assign out_ch.status         = odata_q.status;
	assign out_ch.last           = odata_q.last;

endmodule

/* bench/mpep_checker.sv */
// ----------------------------------------------------------------------------
// mpep_checker - result predictor and scoreboard for the MRP PDU event parser
// Watches both channels, parses every accepted frame byte with its own copy
// of the parse state, and compares each result word against the oldest
// predicted word.
// ----------------------------------------------------------------------------
module mpep_checker (
	input  logic clk,
	input  logic arst_n,
	mpep_in_if   in_ch,
	mpep_out_if  out_ch,
	output int   fail_count,
	output int   words_pending,
	output int   words_seen,
	output int   frames_seen
);
	import mpep_pkg::*;

	localparam int FRAME_LIMIT  = 2048;
	localparam int VALUE_LIMIT  = 4096;
	localparam int MSG_LIMIT    = 256;
	localparam int ALEN_LIMIT   = 64;
	localparam int MSRP_ALEN[5] = '{0, 25, 34, 8, 4};

	// parse state of the predictor
	phase_t      ph;
	logic [10:0] pos;
	logic [6:0]  fcnt;
	logic [15:0] fshift;
	logic        msrp;
	logic [7:0]  atype;
	logic [6:0]  alen;
	logic [10:0] lend;
	logic [12:0] nvals;
	logic [11:0] ecnt;
	logic [8:0]  mcnt;
	logic [9:0]  vcnt;
	logic [7:0]  ver;
	logic        ferr;

	result_t byte_words[$];
	result_t expected_words[$];

	function automatic void clear_frame();
		ph = PH_DST; pos = '0; fcnt = '0; fshift = '0; msrp = 1'b0;
		atype = '0; alen = '0; lend = '0; nvals = '0; ecnt = '0;
		mcnt = '0; vcnt = '0; ver = '0; ferr = 1'b0;
	endfunction

	function automatic void put_word(logic [2:0] kind, logic [11:0] vidx, logic [7:0] val);
		result_t r;
		if (byte_words.size() >= 4) return;
		r = '0;
		r.kind = kind;
		r.is_msrp = msrp;
		r.attr_type = atype;
		r.message_index = mcnt;
		r.vector_index = vcnt;
		r.value_index = vidx;
		r.value = val;
		byte_words = {byte_words, r};
	endfunction

	function automatic void mark_bad();
		ferr = 1'b1;
		ph = PH_ERROR;
	endfunction

	function automatic void close_message(int rem);
		if (msrp && rem < int'(lend)) begin
			mark_bad();
			return;
		end
		if (int'(mcnt) + 1 > MSG_LIMIT) begin
			mark_bad();
			return;
		end
		mcnt = mcnt + 1'b1;
		ph = (msrp && rem > int'(lend)) ? PH_PAD : PH_ATYPE;
	endfunction

	function automatic void next_vector();
		vcnt = vcnt + 1'b1;
		fcnt = '0;
		ph = PH_VHDR;
	endfunction

	function automatic void begin_four();
		if (msrp && atype == ATYPE_LISTENER && nvals != 0) begin
			ecnt = '0;
			fshift = 16'(nvals);
			ph = PH_FOUR;
		end else begin
			next_vector();
		end
	endfunction

	function automatic void begin_three();
		ecnt = '0;
		fshift = 16'(nvals);
		if (fshift == 0) begin_four();
		else ph = PH_THREE;
	endfunction

	// Advance the parse by one byte, re-entering when a message closes early
	function automatic void parse_one(logic [7:0] b, int after);
		bit again;
		logic [15:0] h;
		logic [7:0] ev;
		int j;
		do begin
			again = 1'b0;
			case (ph)
				PH_DST, PH_SRC: begin
					fcnt = fcnt + 1'b1;
					if (fcnt >= 6) begin
						fcnt = '0;
						fshift = '0;
						ph = (ph == PH_DST) ? PH_SRC : PH_ETYPE;
					end
				end
				PH_ETYPE: begin
					fshift = {fshift[7:0], b};
					fcnt = fcnt + 1'b1;
					if (fcnt >= 2) begin
						fcnt = '0;
						if (fshift == ETYPE_VLAN || fshift == ETYPE_QINQ) begin
							ph = PH_TCI;
						end else if (fshift == ETYPE_MSRP || fshift == ETYPE_MVRP) begin
							msrp = (fshift == ETYPE_MSRP);
							ph = PH_VERSION;
						end else begin
							ph = PH_OTHER;
						end
					end
				end
				PH_TCI: begin
					fcnt = fcnt + 1'b1;
					if (fcnt >= 2) begin
						fcnt = '0;
						fshift = '0;
						ph = PH_ETYPE;
					end
				end
				PH_VERSION: begin
					ver = b;
					mcnt = '0;
					ph = PH_ATYPE;
				end
				PH_ATYPE: begin
					if (after == 0 || b == 0) begin
						ph = PH_TAIL;
					end else begin
						atype = b;
						ph = PH_ALEN;
					end
				end
				PH_ALEN: begin
					if (b == 0 || int'(b) > ALEN_LIMIT) mark_bad();
					else if (!msrp && (atype != 1 || b != 2)) mark_bad();
					else if (msrp && atype >= 1 && atype <= 4 &&
							int'(b) != MSRP_ALEN[atype]) mark_bad();
					else begin
						alen = b[6:0];
						vcnt = '0;
						fcnt = '0;
						fshift = '0;
						ph = msrp ? PH_LLEN : PH_VHDR;
					end
				end
				PH_LLEN: begin
					fshift = {fshift[7:0], b};
					fcnt = fcnt + 1'b1;
					if (fcnt >= 2) begin
						if (int'(fshift) > after) begin
							mark_bad();
						end else begin
							lend = 11'(after - int'(fshift));
							fcnt = '0;
							ph = PH_VHDR;
						end
					end
				end
				PH_VHDR: begin
					if (fcnt == 0) begin
						if (after < 1 || (msrp && after + 1 <= int'(lend))) begin
							close_message(after + 1);
							if (!ferr) again = 1'b1;
						end else begin
							fshift = 16'(b);
							fcnt = 7'd1;
						end
					end else begin
						h = {fshift[7:0], b};
						fcnt = '0;
						if (h == 0) close_message(after);
						else if (int'(h[12:0]) > VALUE_LIMIT) mark_bad();
						else begin
							nvals = h[12:0];
							if (h[15:13] == LEAVE_ALL_EVT) put_word(KIND_LEAVE, '0, '0);
							ph = PH_FIRST;
						end
					end
				end
				PH_FIRST: begin
					put_word(KIND_FIRST, 12'(fcnt), b);
					fcnt = fcnt + 1'b1;
					if (fcnt >= alen) begin
						fcnt = '0;
						begin_three();
					end
				end
				PH_THREE: begin
					for (j = 0; j < 3 && fshift > 0; j++) begin
						ev = (j == 0) ? b / 36 : (j == 1) ? (b / 6) % 6 : b % 6;
						put_word(KIND_THREE, ecnt, ev);
						ecnt = ecnt + 1'b1;
						fshift = fshift - 1'b1;
					end
					if (fshift == 0) begin_four();
				end
				PH_FOUR: begin
					for (j = 0; j < 4 && fshift > 0; j++) begin
						ev = (b >> (6 - 2 * j)) & 8'h03;
						put_word(KIND_FOUR, ecnt, ev);
						ecnt = ecnt + 1'b1;
						fshift = fshift - 1'b1;
					end
					if (fshift == 0) next_vector();
				end
				PH_PAD: begin
					if (after <= int'(lend)) ph = PH_ATYPE;
				end
				default: ;
			endcase
		end while (again);
	endfunction

	// Predict the words caused by one accepted byte and queue them
	function automatic void predict_byte(logic [7:0] b, int after);
		logic [1:0] st;
		if (int'(pos) >= FRAME_LIMIT - 1 && after != 0) mark_bad();
		else parse_one(b, after);
		if (int'(pos) < FRAME_LIMIT - 1) pos = pos + 1'b1;
		if (after == 0) begin
			if (!ferr) begin
				case (ph)
					PH_ATYPE, PH_TAIL, PH_OTHER, PH_PAD: ;
					PH_VHDR: begin
						if (fcnt == 0) close_message(0);
						else mark_bad();
					end
					default: mark_bad();
				endcase
			end
			// no room for the status word: drop the events, flag the frame
			if (byte_words.size() >= 4) begin
				mark_bad();
				byte_words.delete();
			end
			st = ferr ? ST_MALFORM : (ph == PH_OTHER ? ST_NOT_MRP : ST_OK);
			atype = '0;
			mcnt = '0;
			vcnt = '0;
			put_word(KIND_STATUS, '0, ver);
			byte_words[byte_words.size() - 1].status = st;
			clear_frame();
		end
		if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last = 1'b1;
		foreach (byte_words[i]) expected_words = {expected_words, byte_words[i]};
		byte_words.delete();
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// Predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			clear_frame();
			expected_words.delete();
			fail_count = 0;
			words_seen = 0;
			frames_seen = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predict_byte(in_ch.data_byte, int'(in_ch.bytes_after));
			if (out_ch.valid && out_ch.ready) begin
				words_seen++;
				if (out_ch.kind == KIND_STATUS) frames_seen++;
				if (expected_words.size() == 0) begin
					$error("unexpected result word, kind %0d", out_ch.kind);
					fail_count++;
				end else begin
					e = expected_words.pop_front();
					check_field("kind", e.kind, out_ch.kind);
					check_field("is_msrp", e.is_msrp, out_ch.is_msrp);
					check_field("attr_type", e.attr_type, out_ch.attr_type);
					check_field("message_index", e.message_index, out_ch.message_index);
					check_field("vector_index", e.vector_index, out_ch.vector_index);
					check_field("value_index", e.value_index, out_ch.value_index);
					check_field("value", e.value, out_ch.value);
					check_field("status", e.status, out_ch.status);
					check_field("last", e.last, out_ch.last);
				end
			end
		end
		words_pending = expected_words.size();
	end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the MRP PDU event parser
// Sends MVRP, MSRP, tagged, foreign, noisy, truncated and oversized-count frames
// in random bursts against a stalling receiver; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
	import mpep_pkg::*;

	localparam int MSRP_ALEN[5] = '{0, 25, 34, 8, 4};

	logic clk;
	logic arst_n;

	mpep_in_if  in_ch();
	mpep_out_if out_ch();

	int fail_count;
	int words_pending;
	int words_seen;
	int frames_seen;

	byte unsigned frame_bytes[$];
	int burst_left;
	int bytes_sent;
	int frames_sent;
	int stall_mode;
	int stall_left;

	mrp_pdu_event_parser_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	mpep_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.fail_count   (fail_count),
		.words_pending(words_pending),
		.words_seen   (words_seen),
		.frames_seen  (frames_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the receiver on a pattern that changes every so often
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_mode = 0;
			stall_left = 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 150);
			end
			stall_left--;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	function automatic void add8(int v);
		frame_bytes = {frame_bytes, 8'(v)};
	endfunction

	function automatic void add16(int v);
		add8(v >> 8);
		add8(v);
	endfunction

	function automatic void add_header(logic [15:0] etype);
		int ntags;
		repeat (12) add8($urandom_range(0, 255));
		ntags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (ntags) begin
			add16($urandom_range(0, 1) ? ETYPE_VLAN : ETYPE_QINQ);
			add16($urandom_range(0, 65535));
		end
		add16(etype);
	endfunction

	// One vector: header, first value, three-packed and optional four-packed bytes
	function automatic void add_vector(int alen, int n, bit four);
		int la;
		la = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(0, 7);
		add16((la << 13) | n);
		repeat (alen) add8($urandom_range(0, 255));
		repeat ((n + 2) / 3)
			add8(($urandom_range(0, 9) == 0) ? $urandom_range(216, 255) : $urandom_range(0, 215));
		if (four) repeat ((n + 3) / 4) add8($urandom_range(0, 255));
	endfunction

	function automatic int small_count();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
	endfunction

	function automatic void add_pdu_end();
		if ($urandom_range(0, 1)) add8(0);
		repeat ($urandom_range(0, 3)) add8($urandom_range(0, 255));
	endfunction

	function automatic void build_mvrp();
		add_header(ETYPE_MVRP);
		add8($urandom_range(0, 255));
		repeat ($urandom_range(1, 3)) begin
			add8(1);
			add8(2);
			repeat ($urandom_range(0, 3)) add_vector(2, small_count(), 1'b0);
			add16(0);
		end
		add_pdu_end();
	endfunction

	// MSRP; with cut set, one listener vector ends the frame on a full packed byte
	function automatic void build_msrp(bit cut);
		int t, alen, p, start, pad, llen;
		add_header(ETYPE_MSRP);
		add8($urandom_range(0, 255));
		repeat (cut ? 1 : $urandom_range(1, 3)) begin
			if (cut) t = ATYPE_LISTENER;
			else t = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 255) : $urandom_range(1, 4);
			alen = (t <= 4) ? MSRP_ALEN[t] : $urandom_range(1, 64);
			add8(t);
			add8(alen);
			p = frame_bytes.size();
			add16(0);
			start = frame_bytes.size();
			if (cut) begin
				add_vector(alen, 4 * $urandom_range(1, 3), 1'b1);
			end else begin
				repeat ($urandom_range(0, 2)) add_vector(alen, small_count(), t == ATYPE_LISTENER);
				if ($urandom_range(0, 3) != 0) add16(0);
			end
			pad = (!cut && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			repeat (pad) add8($urandom_range(0, 255));
			llen = frame_bytes.size() - start;
			frame_bytes[p] = 8'(llen >> 8);
			frame_bytes[p + 1] = 8'(llen);
		end
		if (!cut) add_pdu_end();
	endfunction

	// Break a frame: overwrite a byte or cut it short
	function automatic void corrupt();
		int k;
		if ($urandom_range(0, 3) != 0) return;
		k = $urandom_range(12, frame_bytes.size() - 1);
		if ($urandom_range(0, 1)) frame_bytes[k] = 8'($urandom_range(0, 255));
		else while (frame_bytes.size() > k + 1) void'(frame_bytes.pop_back());
	endfunction

	// Hold valid low until every predicted word has come out
	task automatic drain();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		burst_left = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (words_pending != 0 && guard < 200000);
		@(posedge clk);
	endtask

	task automatic send_frame();
		int rem;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0) begin
					in_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			burst_left--;
			rem = frame_bytes.size() - 1 - i;
			in_ch.valid <= 1'b1;
			in_ch.data_byte <= frame_bytes[i];
			in_ch.bytes_after <= (rem > 2047) ? 11'd2047 : 11'(rem);
			do @(negedge clk); while (!in_ch.ready);
			@(posedge clk);
			bytes_sent++;
		end
		frames_sent++;
		frame_bytes.delete();
	endtask

	initial begin
		#50000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.bytes_after = '0;
		burst_left = 0;
		bytes_sent = 0;
		frames_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: MVRP with leave-all, extreme first-value bytes, largest three-packed byte, end mark
		repeat (12) add8(8'hFF);
		add16(ETYPE_MVRP);
		add8(0);
		add8(1);
		add8(2);
		add16(16'h2003);
		add8(8'h00);
		add8(8'hFF);
		add8(215);
		add16(0);
		add8(0);
		send_frame();
		drain();

		// Random frames of every flavor
		while (bytes_sent < 420) begin
			case ($urandom_range(0, 10))
				0, 1, 2, 3: begin build_mvrp(); corrupt(); end
				4, 5, 6, 7: begin build_msrp(1'b0); corrupt(); end
				8: begin
					add_header(16'($urandom_range(0, 65535)));
					repeat ($urandom_range(0, 20)) add8($urandom_range(0, 255));
				end
				9: repeat ($urandom_range(1, 40)) add8($urandom_range(0, 255));
				default: build_msrp(1'b1);
			endcase
			send_frame();
			if (frames_sent % 6 == 0) drain();
		end

		// Oversized vector count
		add_header(ETYPE_MVRP);
		add8(1);
		add8(1);
		add8(2);
		add16($urandom_range(4097, 8191));
		add16(0);
		send_frame();

		// A few more ordinary frames after the directed one
		repeat (2) begin
			build_msrp(1'b0);
			send_frame();
		end

		in_ch.valid <= 1'b0;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (words_pending != 0 && guard < 500000);
		repeat (20) @(posedge clk);

		$display("covered %0d frames, %0d bytes, %0d result words checked",
			frames_sent, bytes_sent, words_seen);
		$display("frame mix: MVRP, MSRP, tagged, foreign, noise, broken and oversized");
		if (fail_count == 0 && words_pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/mpep_pkg.sv
rtl/mpep_in_if.sv
rtl/mpep_out_if.sv
rtl/mpep_parser.sv
rtl/mpep_emit.sv
rtl/mrp_pdu_event_parser_top.sv
bench/mpep_checker.sv
bench/testbench.sv
